// ----- design/log_record_parser_fnv1a_check_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the log record parser
// Immediate-implication and next-cycle property macros clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef LOG_RECORD_PARSER_FNV1A_CHECK_ASSERT_SVH
`define LOG_RECORD_PARSER_FNV1A_CHECK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRPF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LRPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/lrpf_pkg.sv -----
// ----------------------------------------------------------------------------
// lrpf_pkg
// Types, codes and constants shared by the log record parser modules.
// ----------------------------------------------------------------------------
package lrpf_pkg;

    localparam int KLEN_W     = 21;
    localparam int VLEN_W     = 27;
    localparam int TTL_W      = 64;
    localparam int CNT_W      = 27;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    typedef enum logic [2:0] {
        PH_HDR  = 3'd0,
        PH_OP   = 3'd1,
        PH_KLEN = 3'd2,
        PH_VLEN = 3'd3,
        PH_KEY  = 3'd4,
        PH_VAL  = 3'd5,
        PH_TTL  = 3'd6,
        PH_CHK  = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        KIND_KEY    = 3'd0,
        KIND_VALUE  = 3'd1,
        KIND_ACCEPT = 3'd2,
        KIND_ERROR  = 3'd3,
        KIND_END    = 3'd4
    } t_kind;

    typedef enum logic [3:0] {
        ERR_NO_HEADER      = 4'd0,
        ERR_BAD_HEADER     = 4'd1,
        ERR_BAD_OPCODE     = 4'd2,
        ERR_TRUNC_KLEN     = 4'd3,
        ERR_BAD_KLEN       = 4'd4,
        ERR_TRUNC_VLEN     = 4'd5,
        ERR_BAD_VLEN       = 4'd6,
        ERR_TRUNC_KEY      = 4'd7,
        ERR_TRUNC_VALUE    = 4'd8,
        ERR_TRUNC_TTL      = 4'd9,
        ERR_NO_CHECK       = 4'd10,
        ERR_CHECK_MISMATCH = 4'd11
    } t_err;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHECKSUMMED = 3'd0,
        CFG_STRICT      = 3'd1,
        CFG_PUT_OPCODE  = 3'd2,
        CFG_DEL_OPCODE  = 3'd3,
        CFG_MAX_KEY     = 3'd4,
        CFG_MAX_VALUE   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic              checksummed;
        logic              strict;
        logic [7:0]        put_opcode;
        logic [7:0]        delete_opcode;
        logic [KLEN_W-1:0] max_key_bytes;
        logic [VLEN_W-1:0] max_value_bytes;
    } t_cfg;

    typedef struct packed {
        t_kind                    kind;
        logic [7:0]               out_byte;
        logic                     is_delete;
        logic [KLEN_W-1:0]        key_length;
        logic [VLEN_W-1:0]        value_length;
        logic signed [TTL_W-1:0]  ttl_ms;
        t_err                     error_code;
        logic                     fatal;
    } t_result;

    typedef struct packed {
        logic   halted;
        t_phase phase;
    } t_status;

    // One FNV-1a step: fold the byte in, then multiply by the prime.
    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return x * FNV_PRIME;
    endfunction

    // Magic header, one byte per position.
    function automatic logic [7:0] header_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0: v = 8'h54;
            3'd1: v = 8'h4B;
            3'd2: v = 8'h56;
            3'd3: v = 8'h57;
            3'd4: v = 8'h41;
            3'd5: v = 8'h4C;
            3'd6: v = 8'h33;
            default: v = 8'h0A;
        endcase
        return v;
    endfunction

endpackage

// ----- design/lrpf_cfg.sv -----
// ----------------------------------------------------------------------------
// lrpf_cfg
// Configuration register file of the log record parser.
// ----------------------------------------------------------------------------
module lrpf_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_valid,
    output logic                             o_wr_ready,
    input  logic [lrpf_pkg::CFG_IDX_W-1:0]   i_wr_index,
    input  logic [lrpf_pkg::CFG_DATA_W-1:0]  i_wr_data,
    output lrpf_pkg::t_cfg                   o_cfg
);

    lrpf_pkg::t_cfg r_cfg;

    // Writes are taken in any cycle; an index past the list is dropped.
    assign o_wr_ready = 1'b1;
    assign o_cfg      = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.checksummed     <= 1'b1;
            r_cfg.strict          <= 1'b1;
            r_cfg.put_opcode      <= 8'd1;
            r_cfg.delete_opcode   <= 8'd2;
            r_cfg.max_key_bytes   <= lrpf_pkg::KLEN_W'(1048576);
            r_cfg.max_value_bytes <= lrpf_pkg::VLEN_W'(104857600);
        end else if (i_wr_valid) begin
            case (lrpf_pkg::t_cfg_idx'(i_wr_index))
                lrpf_pkg::CFG_CHECKSUMMED: r_cfg.checksummed <= i_wr_data[0];
                lrpf_pkg::CFG_STRICT:      r_cfg.strict <= i_wr_data[0];
                lrpf_pkg::CFG_PUT_OPCODE:  r_cfg.put_opcode <= i_wr_data[7:0];
                lrpf_pkg::CFG_DEL_OPCODE:  r_cfg.delete_opcode <= i_wr_data[7:0];
                lrpf_pkg::CFG_MAX_KEY: begin
                    r_cfg.max_key_bytes <= i_wr_data[lrpf_pkg::KLEN_W-1:0];
                end
                lrpf_pkg::CFG_MAX_VALUE: begin
                    r_cfg.max_value_bytes <= i_wr_data[lrpf_pkg::VLEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- design/lrpf_core.sv -----
// ----------------------------------------------------------------------------
// lrpf_core
// Parse state, running FNV-1a hash and the registered result stage.
// ----------------------------------------------------------------------------
module lrpf_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lrpf_pkg::t_cfg     i_cfg,
    input  logic               i_in_valid,
    input  logic               i_cmd,
    input  logic [7:0]         i_byte,
    output logic               o_take,
    input  logic               i_out_ready,
    output logic               o_res_valid,
    output lrpf_pkg::t_result  o_res,
    output lrpf_pkg::t_status  o_status
);

    localparam int CNT_W  = lrpf_pkg::CNT_W;
    localparam int KLEN_W = lrpf_pkg::KLEN_W;
    localparam int VLEN_W = lrpf_pkg::VLEN_W;
    localparam int TTL_W  = lrpf_pkg::TTL_W;

    lrpf_pkg::t_phase  r_phase, n_phase, w_eff_phase;
    logic [CNT_W-1:0]  r_count, n_count, w_count_inc;
    logic              r_is_del, n_is_del;
    logic [31:0]       r_klen, n_klen, w_klen_nx;
    logic [31:0]       r_vlen, n_vlen, w_vlen_nx;
    logic [TTL_W-1:0]  r_ttl, n_ttl, w_ttl_nx;
    logic [31:0]       r_hash, n_hash, w_hash_step;
    logic [31:0]       r_chk, n_chk, w_chk_nx;
    logic              r_halted, n_halted;
    logic              r_hdr_bad, n_hdr_bad;
    logic              r_res_valid, n_res_valid;
    lrpf_pkg::t_result r_res, n_res;
    logic              w_has;
    logic [31:0]       w_lane32;
    logic [TTL_W-1:0]  w_lane64;
    logic              w_take;

    function automatic lrpf_pkg::t_result err_res(input lrpf_pkg::t_err code,
                                                  input logic strict);
        lrpf_pkg::t_result r;
        r            = '0;
        r.kind       = lrpf_pkg::KIND_ERROR;
        r.error_code = code;
        r.fatal      = strict;
        return r;
    endfunction

    function automatic lrpf_pkg::t_result accept_res(input logic del,
                                                     input logic [7:0] carried,
                                                     input logic [31:0] klen,
                                                     input logic [31:0] vlen,
                                                     input logic [TTL_W-1:0] ttl);
        lrpf_pkg::t_result r;
        r            = '0;
        r.kind       = lrpf_pkg::KIND_ACCEPT;
        r.out_byte   = carried;
        r.is_delete  = del;
        r.key_length = klen[KLEN_W-1:0];
        if (!del) begin
            r.value_length = vlen[VLEN_W-1:0];
            r.ttl_ms       = $signed(ttl);
        end
        return r;
    endfunction

    function automatic lrpf_pkg::t_result byte_res(input lrpf_pkg::t_kind kind,
                                                   input logic [7:0] b);
        lrpf_pkg::t_result r;
        r          = '0;
        r.kind     = kind;
        r.out_byte = b;
        return r;
    endfunction

    // The item in the input register moves on when the result slot is free.
    assign w_take      = i_in_valid && (!r_res_valid || i_out_ready);
    assign o_take      = w_take;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign o_status    = '{halted: r_halted, phase: r_phase};

    assign w_count_inc = r_count + CNT_W'(1);
    assign w_lane32    = 32'(i_byte) << {r_count[1:0], 3'b000};
    assign w_lane64    = TTL_W'(i_byte) << {r_count[2:0], 3'b000};
    assign w_klen_nx   = r_klen | w_lane32;
    assign w_vlen_nx   = r_vlen | w_lane32;
    assign w_chk_nx    = r_chk | w_lane32;
    assign w_ttl_nx    = r_ttl | w_lane64;

    // In legacy mode a first byte that would open the header is an opcode.
    assign w_eff_phase = (r_phase == lrpf_pkg::PH_HDR && r_count == '0 && !i_cfg.checksummed)
                         ? lrpf_pkg::PH_OP : r_phase;
    assign w_hash_step = lrpf_pkg::fnv_step(
        (w_eff_phase == lrpf_pkg::PH_OP) ? lrpf_pkg::FNV_BASIS : r_hash, i_byte);

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_is_del  = r_is_del;
        n_klen    = r_klen;
        n_vlen    = r_vlen;
        n_ttl     = r_ttl;
        n_hash    = r_hash;
        n_chk     = r_chk;
        n_halted  = r_halted;
        n_hdr_bad = r_hdr_bad;
        w_has     = 1'b0;
        n_res     = '0;

        if (w_take && !r_halted) begin
            if (i_cmd) begin
                // End of stream: clean between records, truncation inside one.
                n_halted = 1'b1;
                w_has    = 1'b1;
                n_res    = byte_res(lrpf_pkg::KIND_END, 8'd0);
                case (r_phase)
                    lrpf_pkg::PH_HDR: begin
                        if (!(r_count == '0 && !i_cfg.checksummed)) begin
                            n_res = err_res(lrpf_pkg::ERR_NO_HEADER, i_cfg.strict);
                        end
                    end
                    lrpf_pkg::PH_OP: begin
                    end
                    lrpf_pkg::PH_KLEN: n_res = err_res(lrpf_pkg::ERR_TRUNC_KLEN, i_cfg.strict);
                    lrpf_pkg::PH_VLEN: n_res = err_res(lrpf_pkg::ERR_TRUNC_VLEN, i_cfg.strict);
                    lrpf_pkg::PH_KEY:  n_res = err_res(lrpf_pkg::ERR_TRUNC_KEY, i_cfg.strict);
                    lrpf_pkg::PH_VAL:  n_res = err_res(lrpf_pkg::ERR_TRUNC_VALUE, i_cfg.strict);
                    lrpf_pkg::PH_TTL:  n_res = err_res(lrpf_pkg::ERR_TRUNC_TTL, i_cfg.strict);
                    default:           n_res = err_res(lrpf_pkg::ERR_NO_CHECK, i_cfg.strict);
                endcase
            end else begin
                case (w_eff_phase)
                    lrpf_pkg::PH_HDR: begin
                        n_hdr_bad = r_hdr_bad ||
                                    (i_byte != lrpf_pkg::header_byte(r_count[2:0]));
                        n_count   = w_count_inc;
                        if (w_count_inc == CNT_W'(8)) begin
                            if (n_hdr_bad) begin
                                n_halted = 1'b1;
                                w_has    = 1'b1;
                                n_res    = err_res(lrpf_pkg::ERR_BAD_HEADER, i_cfg.strict);
                            end else begin
                                n_phase = lrpf_pkg::PH_OP;
                                n_count = '0;
                            end
                        end
                    end
                    lrpf_pkg::PH_OP: begin
                        n_hash  = w_hash_step;
                        n_phase = lrpf_pkg::PH_KLEN;
                        n_count = '0;
                        n_klen  = '0;
                        n_vlen  = '0;
                        n_ttl   = '0;
                        // A put wins when both opcodes are set to the same value.
                        if (i_byte == i_cfg.put_opcode) begin
                            n_is_del = 1'b0;
                        end else if (i_byte == i_cfg.delete_opcode) begin
                            n_is_del = 1'b1;
                        end else begin
                            n_halted = 1'b1;
                            w_has    = 1'b1;
                            n_res    = err_res(lrpf_pkg::ERR_BAD_OPCODE, i_cfg.strict);
                        end
                    end
                    lrpf_pkg::PH_KLEN: begin
                        n_hash  = w_hash_step;
                        n_klen  = w_klen_nx;
                        n_count = w_count_inc;
                        if (w_count_inc == CNT_W'(4)) begin
                            n_count = '0;
                            n_phase = r_is_del ? lrpf_pkg::PH_KEY : lrpf_pkg::PH_VLEN;
                            if (w_klen_nx == '0 || w_klen_nx > 32'(i_cfg.max_key_bytes)) begin
                                n_halted = 1'b1;
                                w_has    = 1'b1;
                                n_res    = err_res(lrpf_pkg::ERR_BAD_KLEN, i_cfg.strict);
                            end
                        end
                    end
                    lrpf_pkg::PH_VLEN: begin
                        n_hash  = w_hash_step;
                        n_vlen  = w_vlen_nx;
                        n_count = w_count_inc;
                        if (w_count_inc == CNT_W'(4)) begin
                            n_count = '0;
                            n_phase = lrpf_pkg::PH_KEY;
                            if (w_vlen_nx > 32'(i_cfg.max_value_bytes)) begin
                                n_halted = 1'b1;
                                w_has    = 1'b1;
                                n_res    = err_res(lrpf_pkg::ERR_BAD_VLEN, i_cfg.strict);
                            end
                        end
                    end
                    lrpf_pkg::PH_KEY: begin
                        n_hash  = w_hash_step;
                        n_count = w_count_inc;
                        w_has   = 1'b1;
                        n_res   = byte_res(lrpf_pkg::KIND_KEY, i_byte);
                        if (w_count_inc >= CNT_W'(r_klen[KLEN_W-1:0])) begin
                            n_count = '0;
                            if (r_is_del) begin
                                if (!i_cfg.checksummed) begin
                                    // Legacy delete closes on its last key byte.
                                    n_phase = lrpf_pkg::PH_OP;
                                    n_res   = accept_res(1'b1, i_byte, r_klen, r_vlen, r_ttl);
                                end else begin
                                    n_phase = lrpf_pkg::PH_CHK;
                                    n_chk   = '0;
                                end
                            end else begin
                                n_phase = (r_vlen == '0) ? lrpf_pkg::PH_TTL : lrpf_pkg::PH_VAL;
                            end
                        end
                    end
                    lrpf_pkg::PH_VAL: begin
                        n_hash  = w_hash_step;
                        n_count = w_count_inc;
                        w_has   = 1'b1;
                        n_res   = byte_res(lrpf_pkg::KIND_VALUE, i_byte);
                        if (w_count_inc >= CNT_W'(r_vlen[VLEN_W-1:0])) begin
                            n_count = '0;
                            n_phase = lrpf_pkg::PH_TTL;
                        end
                    end
                    lrpf_pkg::PH_TTL: begin
                        n_hash  = w_hash_step;
                        n_ttl   = w_ttl_nx;
                        n_count = w_count_inc;
                        if (w_count_inc == CNT_W'(8)) begin
                            n_count = '0;
                            if (i_cfg.checksummed) begin
                                n_phase = lrpf_pkg::PH_CHK;
                                n_chk   = '0;
                            end else begin
                                n_phase = lrpf_pkg::PH_OP;
                                w_has   = 1'b1;
                                n_res   = accept_res(r_is_del, 8'd0, r_klen, r_vlen, w_ttl_nx);
                            end
                        end
                    end
                    default: begin
                        n_chk   = w_chk_nx;
                        n_count = w_count_inc;
                        if (w_count_inc == CNT_W'(4)) begin
                            n_count = '0;
                            n_phase = lrpf_pkg::PH_OP;
                            w_has   = 1'b1;
                            if (w_chk_nx != r_hash) begin
                                n_halted = 1'b1;
                                n_res    = err_res(lrpf_pkg::ERR_CHECK_MISMATCH, i_cfg.strict);
                            end else begin
                                n_res = accept_res(r_is_del, 8'd0, r_klen, r_vlen, r_ttl);
                            end
                        end
                    end
                endcase
            end
        end

        if (w_take) begin
            n_res_valid = w_has;
        end else if (i_out_ready) begin
            n_res_valid = 1'b0;
        end else begin
            n_res_valid = r_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= lrpf_pkg::PH_HDR;
            r_count     <= '0;
            r_halted    <= 1'b0;
            r_hdr_bad   <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_halted    <= n_halted;
            r_hdr_bad   <= n_hdr_bad;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_del <= n_is_del;
        r_klen   <= n_klen;
        r_vlen   <= n_vlen;
        r_ttl    <= n_ttl;
        r_hash   <= n_hash;
        r_chk    <= n_chk;
        if (w_take) begin
            r_res <= n_res;
        end
    end

endmodule

// ----- design/log_record_parser_fnv1a_check.sv -----
// ----------------------------------------------------------------------------
// log_record_parser_fnv1a_check
// Streaming parser for length-prefixed log records with FNV-1a-32 checks.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one item per log byte in s_axis_tdata, with
//   s_axis_tuser set to 1 on the single end-of-stream item. The master stream
//   returns key bytes, value bytes, one verdict per record, an error or a
//   clean end, with the kind in m_axis_tuser and the rest in m_axis_tdata.
//   Registers are written through the cfg channel, which is always ready;
//   write it only while no item is in flight.
//   Each item passes through the input register, then the result register.
//   Throughput: one item per cycle while the receiver does not stall; the hash
//   step, one 32-bit multiply by the FNV prime, and the phase update fit
//   between the two registers. Items that cause no result leave no bubble.
//   When the receiver stalls, the result register holds and the input
//   register keeps one more item, then s_axis_tready drops.
//   Reset clears the parse state and restores the register defaults. After
//   an error or an end of stream, later items are taken and dropped until
//   the next reset.
// ----------------------------------------------------------------------------
`include "log_record_parser_fnv1a_check_assert.svh"

module log_record_parser_fnv1a_check (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [7:0] data_byte
    input  logic [0:0]                       s_axis_tuser,  // [0] command
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] out_byte, [8] is_delete, [29:9] key_length, [56:30] value_length,
    // [120:57] ttl_ms, [124:121] error_code, [125] fatal, [127:126] zero
    output logic [127:0]                     m_axis_tdata,
    output logic [2:0]                       m_axis_tuser,  // [2:0] result_kind
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lrpf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lrpf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    lrpf_pkg::t_cfg    w_cfg;
    lrpf_pkg::t_result w_res;
    lrpf_pkg::t_status w_status;
    logic              w_take;
    logic              r_in_valid;
    logic              r_in_cmd;
    logic [7:0]        r_in_byte;

    lrpf_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg_valid),
        .o_wr_ready (o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    assign s_axis_tready = !r_in_valid || w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd  <= s_axis_tuser[0];
            r_in_byte <= s_axis_tdata;
        end
    end

    lrpf_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (r_in_valid),
        .i_cmd       (r_in_cmd),
        .i_byte      (r_in_byte),
        .o_take      (w_take),
        .i_out_ready (m_axis_tready),
        .o_res_valid (m_axis_tvalid),
        .o_res       (w_res),
        .o_status    (w_status)
    );

    assign m_axis_tuser = w_res.kind;
    assign m_axis_tdata = {2'b00, w_res.fatal, w_res.error_code, w_res.ttl_ms,
                           w_res.value_length, w_res.key_length, w_res.is_delete,
                           w_res.out_byte};

    // An error or clean-end result is only ever produced by a halting item.
    `LRPF_ASSERT_SAME(a_terminal_halts, m_axis_tvalid && (m_axis_tuser == lrpf_pkg::KIND_ERROR || m_axis_tuser == lrpf_pkg::KIND_END), w_status.halted, "terminal result without halt")
    `LRPF_ASSERT_NEXT(a_halt_sticky, w_status.halted, w_status.halted, "halt released before reset")
    // Once the terminal result is taken, nothing more may come out.
    `LRPF_ASSERT_NEXT(a_quiet_after_end, m_axis_tvalid && m_axis_tready && (m_axis_tuser == lrpf_pkg::KIND_ERROR || m_axis_tuser == lrpf_pkg::KIND_END), !m_axis_tvalid, "result after terminal item")
    `LRPF_ASSERT_NEXT(a_header_once, w_status.phase != lrpf_pkg::PH_HDR, w_status.phase != lrpf_pkg::PH_HDR, "header phase entered again")

endmodule

// ----- verif/log_record_parser_fnv1a_check_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Log record parser testbench
// Streams a log, checksummed at first, through the parser: the magic header, a few
// fixed records, then groups of random put and delete records under changing
// register settings and handshake pressure. A single corrupted, truncated or
// cleanly ended record closes the stream, followed by items the parser must
// drop. A scoreboard recomputes every result and checks each field.
// ----------------------------------------------------------------------------
module log_record_parser_fnv1a_check_test;

    import lrpf_pkg::*;

    // Magic header, first byte in the lowest bits.
    localparam bit [63:0] MAGIC_WORD = 64'h0A33_4C41_5756_4B54;
    localparam bit [63:0] TTL_MIN    = 64'h8000_0000_0000_0000;
    localparam bit [63:0] TTL_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;

    class wal_parse_tracker;
        t_result     pending_results[$];
        int unsigned bad_results;

        bit          cks, strict;
        bit [7:0]    put_op, del_op;
        bit [20:0]   max_key;
        bit [26:0]   max_val;

        t_phase      phase;
        bit [31:0]   nbytes, klen, vlen, hash, chk;
        bit [63:0]   ttl;
        bit          del_rec, halted, hdr_bad;

        function new();
            cks     = 1'b1;
            strict  = 1'b1;
            put_op  = 8'd1;
            del_op  = 8'd2;
            max_key = 21'd1048576;
            max_val = 27'd104857600;
            phase   = PH_HDR;
            hash    = FNV_BASIS;
        endfunction

        static function bit [31:0] fold(bit [31:0] h, bit [7:0] b);
            return (h ^ {24'd0, b}) * FNV_PRIME;
        endfunction

        function void note_reg_write(t_cfg_idx idx, bit [26:0] val);
            case (idx)
                CFG_CHECKSUMMED: cks = val[0];
                CFG_STRICT:      strict = val[0];
                CFG_PUT_OPCODE:  put_op = val[7:0];
                CFG_DEL_OPCODE:  del_op = val[7:0];
                CFG_MAX_KEY:     max_key = val[20:0];
                CFG_MAX_VALUE:   max_val = val;
                default: ;
            endcase
        endfunction

        function void queue_result(t_kind k, bit [7:0] b, bit d, bit [20:0] kl,
                                   bit [26:0] vl, bit [63:0] t, t_err e, bit f);
            t_result r;
            r.kind         = k;
            r.out_byte     = b;
            r.is_delete    = d;
            r.key_length   = kl;
            r.value_length = vl;
            r.ttl_ms       = t;
            r.error_code   = e;
            r.fatal        = f;
            pending_results.push_back(r);
        endfunction

        function void fail(t_err e);
            halted = 1'b1;
            queue_result(KIND_ERROR, 8'd0, 1'b0, '0, '0, '0, e, strict);
        endfunction

        function void close_record(bit [7:0] carried);
            phase  = PH_OP;
            nbytes = 0;
            if (del_rec)
                queue_result(KIND_ACCEPT, carried, 1'b1, klen[20:0], '0, '0,
                             ERR_NO_HEADER, 1'b0);
            else
                queue_result(KIND_ACCEPT, carried, 1'b0, klen[20:0], vlen[26:0], ttl,
                             ERR_NO_HEADER, 1'b0);
        endfunction

        // Advances the parse state by one accepted item and queues its result.
        function void note_item(bit cmd, bit [7:0] b);
            int unsigned sh;
            sh = (nbytes & 7) * 8;
            if (halted)
                return;

            if (cmd) begin
                case (phase)
                    PH_HDR: begin
                        if (nbytes != 0 || cks) begin
                            fail(ERR_NO_HEADER);
                            return;
                        end
                    end
                    PH_OP: ;
                    PH_KLEN: begin fail(ERR_TRUNC_KLEN);  return; end
                    PH_VLEN: begin fail(ERR_TRUNC_VLEN);  return; end
                    PH_KEY:  begin fail(ERR_TRUNC_KEY);   return; end
                    PH_VAL:  begin fail(ERR_TRUNC_VALUE); return; end
                    PH_TTL:  begin fail(ERR_TRUNC_TTL);   return; end
                    default: begin fail(ERR_NO_CHECK);    return; end
                endcase
                halted = 1'b1;
                queue_result(KIND_END, 8'd0, 1'b0, '0, '0, '0, ERR_NO_HEADER, 1'b0);
                return;
            end

            // The header is only expected if checksumming is on at the first byte.
            if (phase == PH_HDR) begin
                if (nbytes == 0 && !cks) begin
                    phase = PH_OP;
                end else begin
                    if (b != MAGIC_WORD[8 * (nbytes & 7) +: 8])
                        hdr_bad = 1'b1;
                    nbytes++;
                    if (nbytes >= 8) begin
                        if (hdr_bad) begin
                            fail(ERR_BAD_HEADER);
                            return;
                        end
                        phase  = PH_OP;
                        nbytes = 0;
                    end
                    return;
                end
            end

            case (phase)
                PH_OP: begin
                    hash = fold(FNV_BASIS, b);
                    if (b == put_op) begin
                        del_rec = 1'b0;
                    end else if (b == del_op) begin
                        del_rec = 1'b1;
                    end else begin
                        fail(ERR_BAD_OPCODE);
                        return;
                    end
                    phase  = PH_KLEN;
                    nbytes = 0;
                    klen   = 0;
                    vlen   = 0;
                    ttl    = 0;
                end
                PH_KLEN: begin
                    hash = fold(hash, b);
                    klen = klen | (32'(b) << sh);
                    nbytes++;
                    if (nbytes >= 4) begin
                        if (klen == 0 || klen > max_key) begin
                            fail(ERR_BAD_KLEN);
                            return;
                        end
                        nbytes = 0;
                        phase  = del_rec ? PH_KEY : PH_VLEN;
                    end
                end
                PH_VLEN: begin
                    hash = fold(hash, b);
                    vlen = vlen | (32'(b) << sh);
                    nbytes++;
                    if (nbytes >= 4) begin
                        if (vlen > max_val) begin
                            fail(ERR_BAD_VLEN);
                            return;
                        end
                        nbytes = 0;
                        phase  = PH_KEY;
                    end
                end
                PH_KEY: begin
                    hash = fold(hash, b);
                    nbytes++;
                    if (nbytes >= klen) begin
                        nbytes = 0;
                        if (del_rec) begin
                            // A legacy delete closes on its last key byte.
                            if (!cks) begin
                                close_record(b);
                                return;
                            end
                            phase = PH_CHK;
                            chk   = 0;
                        end else begin
                            phase = (vlen == 0) ? PH_TTL : PH_VAL;
                        end
                    end
                    queue_result(KIND_KEY, b, 1'b0, '0, '0, '0, ERR_NO_HEADER, 1'b0);
                end
                PH_VAL: begin
                    hash = fold(hash, b);
                    nbytes++;
                    if (nbytes >= vlen) begin
                        nbytes = 0;
                        phase  = PH_TTL;
                    end
                    queue_result(KIND_VALUE, b, 1'b0, '0, '0, '0, ERR_NO_HEADER, 1'b0);
                end
                PH_TTL: begin
                    hash = fold(hash, b);
                    ttl  = ttl | (64'(b) << sh);
                    nbytes++;
                    if (nbytes >= 8) begin
                        if (cks) begin
                            phase  = PH_CHK;
                            nbytes = 0;
                            chk    = 0;
                        end else begin
                            close_record(8'd0);
                        end
                    end
                end
                default: begin
                    chk = chk | (32'(b) << sh);
                    nbytes++;
                    if (nbytes >= 4) begin
                        if (chk != hash)
                            fail(ERR_CHECK_MISMATCH);
                        else
                            close_record(8'd0);
                    end
                end
            endcase
        endfunction

        function void check_result(logic [2:0] kind, logic [127:0] data);
            t_result want;
            if (pending_results.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("%0t: unpredicted result kind %0d data %h", $time, kind, data);
                return;
            end
            want = pending_results.pop_front();
            if (kind !== want.kind || data[7:0] !== want.out_byte ||
                data[8] !== want.is_delete || data[29:9] !== want.key_length ||
                data[56:30] !== want.value_length || data[120:57] !== want.ttl_ms ||
                data[124:121] !== want.error_code || data[125] !== want.fatal) begin
                bad_results++;
                if (bad_results <= 10)
                    $display({"%0t: result mismatch\n",
                              "  expected kind %0d byte %h del %b klen %0d vlen %0d ",
                              "ttl %h err %0d fatal %b\n",
                              "  actual   kind %0d byte %h del %b klen %0d vlen %0d ",
                              "ttl %h err %0d fatal %b"},
                             $time, want.kind, want.out_byte, want.is_delete,
                             want.key_length, want.value_length, want.ttl_ms,
                             want.error_code, want.fatal,
                             kind, data[7:0], data[8], data[29:9], data[56:30],
                             data[120:57], data[124:121], data[125]);
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata  = 8'd0;   // [7:0] data_byte
    logic [0:0]   s_axis_tuser  = 1'b0;   // [0] command
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [7:0] out_byte, [8] is_delete, [29:9] key_length, [56:30] value_length,
    // [120:57] ttl_ms, [124:121] error_code, [125] fatal, [127:126] zero
    logic [127:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;           // [2:0] result_kind
    logic         i_cfg_valid   = 1'b0;
    logic         o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    log_record_parser_fnv1a_check dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    wal_parse_tracker tracker;
    int unsigned      send_idle_pct;
    int unsigned      recv_stall_pct;
    int unsigned      items_sent;

    // Register values as the stimulus side sees them.
    bit               cfg_cks = 1'b1;
    bit [7:0]         cfg_put = 8'd1;
    bit [7:0]         cfg_del = 8'd2;
    bit [20:0]        cfg_max_key = 21'd1048576;
    bit [26:0]        cfg_max_val = 27'd104857600;
    bit [7:0]         rec_bytes[$];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                tracker.note_reg_write(t_cfg_idx'(i_cfg_index), i_cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                tracker.note_item(s_axis_tuser[0], s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_result(m_axis_tuser, m_axis_tdata);
        end
    end

    task automatic send_item(input bit cmd, input bit [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic send_record();
        foreach (rec_bytes[i])
            send_item(1'b0, rec_bytes[i]);
    endtask

    // Holds the sender until every predicted result is out, then lets the
    // pipeline settle so items without a result are through as well.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input bit [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic program_config(input bit cks, input bit strict, input bit [7:0] put_op,
                                  input bit [7:0] del_op, input bit [20:0] max_key,
                                  input bit [26:0] max_val);
        cfg_cks     = cks;
        cfg_put     = put_op;
        cfg_del     = del_op;
        cfg_max_key = max_key;
        cfg_max_val = max_val;
        write_reg(CFG_CHECKSUMMED, 27'(cks));
        write_reg(CFG_STRICT, 27'(strict));
        write_reg(CFG_PUT_OPCODE, 27'(put_op));
        write_reg(CFG_DEL_OPCODE, 27'(del_op));
        write_reg(CFG_MAX_KEY, 27'(max_key));
        write_reg(CFG_MAX_VALUE, max_val);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int unsigned mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
        endcase
    endtask

    // Fills rec_bytes with one well-formed record for the current settings.
    function automatic void build_record(input bit is_del, input bit [31:0] klen,
                                         input bit [31:0] vlen, input bit [63:0] ttl);
        bit [31:0] h;
        rec_bytes.delete();
        rec_bytes.push_back(is_del ? cfg_del : cfg_put);
        for (int i = 0; i < 4; i++)
            rec_bytes.push_back(klen[8*i +: 8]);
        if (!is_del)
            for (int i = 0; i < 4; i++)
                rec_bytes.push_back(vlen[8*i +: 8]);
        for (int i = 0; i < klen; i++)
            rec_bytes.push_back(8'($urandom_range(255)));
        if (!is_del) begin
            for (int i = 0; i < vlen; i++)
                rec_bytes.push_back(8'($urandom_range(255)));
            for (int i = 0; i < 8; i++)
                rec_bytes.push_back(ttl[8*i +: 8]);
        end
        if (cfg_cks) begin
            h = FNV_BASIS;
            foreach (rec_bytes[i])
                h = wal_parse_tracker::fold(h, rec_bytes[i]);
            for (int i = 0; i < 4; i++)
                rec_bytes.push_back(h[8*i +: 8]);
        end
    endfunction

    function automatic bit [63:0] random_ttl();
        case ($urandom_range(4))
            0: return 64'd0;
            1: return TTL_MIN;
            2: return TTL_MAX;
            3: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void random_record();
        bit          is_del;
        int unsigned klen_cap, vlen_cap;
        // Equal opcodes mean every record is a put.
        is_del   = (cfg_put != cfg_del) && ($urandom_range(2) == 0);
        klen_cap = ($urandom_range(9) == 0) ? 48 : 6;
        vlen_cap = ($urandom_range(9) == 0) ? 40 : 8;
        if (klen_cap > cfg_max_key)
            klen_cap = cfg_max_key;
        if (vlen_cap > cfg_max_val)
            vlen_cap = cfg_max_val;
        build_record(is_del, $urandom_range(klen_cap, 1), $urandom_range(vlen_cap, 0),
                     random_ttl());
    endfunction

    initial begin
        int unsigned target, finale;
        bit [7:0]    op_a, op_b;
        bit [31:0]   bad_len;
        int unsigned flip_at;

        tracker = new();
        set_idling(0);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: header, puts at both TTL extremes, a checked delete.
        for (int i = 0; i < 8; i++)
            send_item(1'b0, MAGIC_WORD[8*i +: 8]);
        build_record(1'b0, 1, 0, TTL_MIN);
        send_record();
        build_record(1'b0, 2, 1, TTL_MAX);
        send_record();
        build_record(1'b1, 1, 0, 64'd0);
        send_record();

        for (int g = 0; g < 8; g++) begin
            drain();
            set_idling(g % 4);
            case (g)
                0: program_config(1'b1, 1'b0, 8'd0, 8'd255, 21'd1, 27'd0);
                1: program_config(1'b0, 1'b1, 8'd255, 8'd0, 21'd1048576, 27'd104857600);
                2: begin
                    op_a = 8'($urandom_range(255));
                    program_config(1'b1, 1'($urandom_range(1)), op_a, op_a,
                                   21'($urandom_range(12, 1)), 27'($urandom_range(12)));
                end
                default: begin
                    op_a = 8'($urandom_range(255));
                    op_b = ($urandom_range(5) == 0) ? op_a : 8'($urandom_range(255));
                    program_config(1'($urandom_range(1)), 1'($urandom_range(1)), op_a, op_b,
                                   ($urandom_range(2) == 0) ? 21'($urandom_range(8, 1))
                                                            : 21'($urandom_range(1048576, 1)),
                                   ($urandom_range(2) == 0) ? 27'($urandom_range(8))
                                                            : 27'($urandom_range(104857600)));
                end
            endcase
            target = items_sent + 135;
            while (items_sent < target) begin
                if ($urandom_range(15) == 0)
                    drain();
                random_record();
                send_record();
            end
        end

        // Closing record: a clean end, a truncation or one corruption.
        drain();
        set_idling($urandom_range(3));
        finale = $urandom_range(5);
        op_a   = 8'($urandom_range(255));
        op_b   = op_a + 8'($urandom_range(254, 1));
        program_config((finale == 5) ? 1'b1 : 1'($urandom_range(1)), 1'($urandom_range(1)),
                       op_a, op_b, 21'($urandom_range(40, 4)), 27'($urandom_range(40, 4)));
        build_record((finale != 4) && ($urandom_range(1) == 1), $urandom_range(4, 2),
                     $urandom_range(4, 2), random_ttl());
        case (finale)
            0: rec_bytes = rec_bytes[0:$urandom_range(rec_bytes.size() - 1, 1) - 1];
            1: rec_bytes.delete();
            2: begin
                do rec_bytes[0] = 8'($urandom_range(255));
                while (rec_bytes[0] == cfg_put || rec_bytes[0] == cfg_del);
            end
            3, 4: begin
                case ($urandom_range(2))
                    0: bad_len = 0;
                    1: bad_len = (finale == 3) ? cfg_max_key + 1 : cfg_max_val + 1;
                    default: bad_len = $urandom | 32'h8000_0000;
                endcase
                // A zero value length is legal, so bump it past the limit instead.
                if (finale == 4 && bad_len == 0)
                    bad_len = 32'hFFFF_FFFF;
                for (int i = 0; i < 4; i++)
                    rec_bytes[((finale == 3) ? 1 : 5) + i] = bad_len[8*i +: 8];
            end
            default: begin
                flip_at = rec_bytes.size() - 1 - $urandom_range(3);
                rec_bytes[flip_at] = rec_bytes[flip_at] ^ (8'd1 << $urandom_range(7));
            end
        endcase
        send_record();
        send_item(1'b1, 8'($urandom_range(255)));
        // The parser is halted now; these must all be dropped.
        repeat (8)
            send_item(1'($urandom_range(1)), 8'($urandom_range(255)));

        drain();
        repeat (10) @(posedge i_clk);
        if (tracker.bad_results == 0)
            $display("log_record_parser_fnv1a_check_test passed");
        else
            $display("log_record_parser_fnv1a_check_test failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("log_record_parser_fnv1a_check_test failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/lrpf_pkg.sv
design/lrpf_cfg.sv
design/lrpf_core.sv
design/log_record_parser_fnv1a_check.sv
verif/log_record_parser_fnv1a_check_test.sv
